>>> rtl/bsli_pkg.sv
// ----------------------------------------------------------------------------
// bsli_pkg: shared widths and codes for the bounded sorted list core
// Field widths, register indexes, status codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bsli_pkg;

    localparam int CNT_W  = 9;
    localparam int IDX_W  = 8;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 9;

    localparam int DEPTH_DEFAULT = 256;

    localparam logic [CNT_W-1:0] CAP_MAX   = 9'd256;
    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_SORTED   = 1'b1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

endpackage

`default_nettype wire

>>> rtl/bounded_sorted_list_insert_core.sv
// ----------------------------------------------------------------------------
// bounded_sorted_list_insert_core: bounded list with append or sorted insert
// Entries live in one simple dual-port RAM (one write, one registered read).
// A read goes through RDWAIT and DONE; a refused or appended insert goes straight
//   to DONE; a sorted insert runs a binary search (SEARCH, then CMP on the RAM
//   read, per probe), a shift that moves one entry per cycle, then PLACE.
// One item in flight; the next beat is taken while the result waits to leave.
// Reset clears count, mode and output valid, sets capacity to 256; the RAM
//   is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_sorted_list_insert_core
    import bsli_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    mode,
    input  wire logic signed [VAL_W-1:0] value,
    input  wire logic [IDX_W-1:0]        index,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [STAT_W-1:0]            status,
    output logic [IDX_W-1:0]             insert_position,
    output logic signed [VAL_W-1:0]      read_value,
    output logic [CNT_W-1:0]             element_total,
    output logic                         is_full,
    output logic                         is_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RDWAIT = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_CMP    = 3'd3;
    localparam logic [2:0] ST_SHIFT  = 3'd4;
    localparam logic [2:0] ST_PLACE  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [VAL_W-1:0] entry_mem [DEPTH];
    logic [VAL_W-1:0] rd_data_reg;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  capacity_reg;
    logic              sorted_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [STAT_W-1:0] op_stat_reg, op_stat_next;
    logic [VAL_W-1:0]  op_rd_reg, op_rd_next;

    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [IDX_W-1:0]  pos_out_reg;
    logic [VAL_W-1:0]  rd_out_reg;
    logic [CNT_W-1:0]  total_reg;
    logic              full_reg;
    logic              empty_reg;

    logic              mem_we;
    logic [CNT_W-1:0]  mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    logic [CNT_W-1:0]  mem_raddr;

    logic [CNT_W-1:0]  cap_eff;
    logic              list_full;
    logic              in_accept;
    logic              out_free;
    logic [CNT_W-1:0]  mid_calc;

    assign cap_eff   = (32'(capacity_reg) > DEPTH) ? CNT_W'(DEPTH) : capacity_reg;
    assign list_full = (count_reg >= cap_eff);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        val_next       = val_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pos_next       = pos_reg;
        i_next         = i_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        op_stat_next   = op_stat_reg;
        op_rd_next     = op_rd_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg;
        mem_wdata      = val_reg;
        mem_raddr      = mid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    val_next     = value;
                    pos_next     = '0;
                    op_rd_next   = '0;
                    op_stat_next = STAT_OK;
                    if (mode == OP_READ)
                    begin
                        mem_raddr = {1'b0, index};
                        if (({1'b0, index} < count_reg) && (32'(index) < DEPTH))
                        begin
                            state_next = ST_RDWAIT;
                        end
                        else
                        begin
                            op_stat_next = STAT_RANGE;
                            state_next   = ST_DONE;
                        end
                    end
                    else if (list_full)
                    begin
                        op_stat_next = STAT_FULL;
                        state_next   = ST_DONE;
                    end
                    else if (!sorted_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg;
                        mem_wdata  = value;
                        pos_next   = count_reg;
                        count_next = count_reg + 9'd1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = count_reg;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_RDWAIT:
            begin
                op_rd_next = rd_data_reg;
                state_next = ST_DONE;
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_raddr  = mid_calc;
                    mid_next   = mid_calc;
                    state_next = ST_CMP;
                end
                else
                begin
                    pos_next   = lo_reg;
                    i_next     = count_reg;
                    state_next = ST_SHIFT;
                end
            end
            ST_CMP:
            begin
                if ($signed(rd_data_reg) > $signed(val_reg))
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + 9'd1;
                end
                state_next = ST_SEARCH;
            end
            ST_SHIFT:
            begin
                // read i-1 now, write it to i in the next cycle
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    mem_wdata = rd_data_reg;
                end
                if (i_reg > pos_reg)
                begin
                    mem_raddr      = i_reg - 9'd1;
                    pend_next      = 1'b1;
                    pend_addr_next = i_reg;
                    i_next         = i_reg - 9'd1;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + 9'd1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[AW'(mem_waddr)] <= mem_wdata;
        end
        rd_data_reg <= entry_mem[AW'(mem_raddr)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_RESET;
            sorted_reg    <= 1'b0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CAPACITY: capacity_reg <= cfg_data;
                    REG_SORTED:   sorted_reg   <= cfg_data[0];
                    default:      sorted_reg   <= sorted_reg;
                endcase
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        pos_reg       <= pos_next;
        i_reg         <= i_next;
        pend_addr_reg <= pend_addr_next;
        op_stat_reg   <= op_stat_next;
        op_rd_reg     <= op_rd_next;
        if (state_reg == ST_DONE && out_free)
        begin
            status_reg  <= op_stat_reg;
            pos_out_reg <= pos_reg[IDX_W-1:0];
            rd_out_reg  <= op_rd_reg;
            total_reg   <= count_reg;
            full_reg    <= list_full;
            empty_reg   <= (count_reg == '0);
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign insert_position = pos_out_reg;
    assign read_value      = rd_out_reg;
    assign element_total   = total_reg;
    assign is_full         = full_reg;
    assign is_empty        = empty_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_MAX)
        else $error("entry count above maximum");

    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH || state_reg == ST_CMP) |-> lo_reg <= hi_reg)
        else $error("search bounds crossed");

    a_shift_floor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SHIFT |-> (i_reg >= pos_reg && pos_reg <= count_reg))
        else $error("shift pointer below insert position");

    a_place_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PLACE |=> count_reg == 9'($past(count_reg) + 9'd1))
        else $error("count not advanced on sorted insert");

    a_full_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH || state_reg == ST_SHIFT) |-> !list_full)
        else $error("insert in progress on a full list");

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for bounded_sorted_list_insert_core
// A directed table covers empty reads, zero and reduced capacity, appends up
// to full, refused inserts, mode switches and capacity above the list depth.
// Random phases then sweep capacity and ordering while a shadow list predicts
// every result. Both sides idle at random; the receiver also holds off once
// for a long stretch so that the core backs up and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import bsli_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = DEPTH_DEFAULT;
    localparam int WATCHDOG    = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_PHASES  = 7;

    localparam logic [CFG_W-1:0] PHASE_CAP [NUM_PHASES] =
        '{9'd40, 9'd100, 9'd511, 9'd256, 9'd1, 9'd0, 9'd300};
    localparam bit PHASE_SORTED [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam int PHASE_ITEMS [NUM_PHASES]  = '{300, 250, 600, 250, 150, 150, 200};
    localparam int PHASE_INS_PCT [NUM_PHASES] = '{60, 50, 70, 30, 40, 40, 40};

    typedef struct {
        logic [STAT_W-1:0]       status;
        logic [IDX_W-1:0]        pos;
        logic signed [VAL_W-1:0] rdval;
        logic [CNT_W-1:0]        total;
        logic                    full;
        logic                    empty;
    } list_result_t;

    typedef struct {
        bit                      is_cfg;
        logic                    sel;
        logic [CFG_W-1:0]        word;
        logic                    op;
        logic signed [VAL_W-1:0] val;
        logic [IDX_W-1:0]        idx;
        bit                      typed;
        list_result_t            want;
    } plan_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic                    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic                    mode;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
    logic                    out_valid;
    logic                    out_stall;
    logic [STAT_W-1:0]       status;
    logic [IDX_W-1:0]        insert_position;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        element_total;
    logic                    is_full;
    logic                    is_empty;

    // shadow copy of the list and its registers
    logic signed [VAL_W-1:0] shadow_mem [LIST_DEPTH];
    int                      shadow_len;
    logic [CFG_W-1:0]        shadow_cap;
    bit                      shadow_sorted;

    list_result_t pending_results [$];
    plan_row_t    plan [$];
    int           n_errors;
    int           quiet_cycles;
    bit           steady;
    bit           hold_req;

    bounded_sorted_list_insert_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .value           (value),
        .index           (index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .insert_position (insert_position),
        .read_value      (read_value),
        .element_total   (element_total),
        .is_full         (is_full),
        .is_empty        (is_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic list_result_t apply_item(input logic op,
                                                input logic signed [VAL_W-1:0] v,
                                                input logic [IDX_W-1:0] ix);
        list_result_t r;
        int lim;
        int lo;
        int hi;
        int mid;
        int slot;
        r.status = STAT_OK;
        r.pos    = '0;
        r.rdval  = '0;
        lim = (shadow_cap > CAP_MAX) ? int'(CAP_MAX) : int'(shadow_cap);
        if (op == OP_INSERT)
        begin
            if (shadow_len >= lim)
                r.status = STAT_FULL;
            else
            begin
                if (shadow_sorted)
                begin
                    lo = 0;
                    hi = shadow_len;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (shadow_mem[mid] > v)
                            hi = mid;
                        else
                            lo = mid + 1;
                    end
                    slot = lo;
                end
                else
                    slot = shadow_len;
                for (int i = shadow_len; i > slot; i--)
                    shadow_mem[i] = shadow_mem[i-1];
                shadow_mem[slot] = v;
                shadow_len++;
                r.pos = IDX_W'(slot);
            end
        end
        else if (int'(ix) < shadow_len)
            r.rdval = shadow_mem[ix];
        else
            r.status = STAT_RANGE;
        r.total = CNT_W'(shadow_len);
        r.full  = (shadow_len >= lim);
        r.empty = (shadow_len == 0);
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic sel, input int word);
        plan_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.sel    = sel;
        row.word   = CFG_W'(word);
        return row;
    endfunction

    function automatic plan_row_t op_row(input logic op, input logic [VAL_W-1:0] v,
                                         input int ix);
        plan_row_t row;
        row = '{default: '0};
        row.op  = op;
        row.val = v;
        row.idx = IDX_W'(ix);
        return row;
    endfunction

    function automatic plan_row_t chk_row(input logic op, input logic [VAL_W-1:0] v,
                                          input int ix, input logic [STAT_W-1:0] st,
                                          input int pos, input logic [VAL_W-1:0] rd,
                                          input int total, input bit full, input bit empty);
        plan_row_t row;
        row = op_row(op, v, ix);
        row.typed       = 1'b1;
        row.want.status = st;
        row.want.pos    = IDX_W'(pos);
        row.want.rdval  = rd;
        row.want.total  = CNT_W'(total);
        row.want.full   = full;
        row.want.empty  = empty;
        return row;
    endfunction

    task automatic report(input string what, input logic [VAL_W-1:0] got,
                          input logic [VAL_W-1:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        n_errors++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [CFG_W-1:0] word);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= word;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (sel == REG_CAPACITY)
            shadow_cap = word;
        else
            shadow_sorted = word[0];
    endtask

    task automatic send_item(input logic op, input logic signed [VAL_W-1:0] v,
                             input logic [IDX_W-1:0] ix, input bit typed,
                             input list_result_t want);
        list_result_t exp;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        value    <= v;
        index    <= ix;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        exp = apply_item(op, v, ix);
        if (typed)
            exp = want;
        pending_results.push_back(exp);
    endtask

    task automatic random_item(input int ins_pct);
        logic                    op;
        logic signed [VAL_W-1:0] v;
        logic [IDX_W-1:0]        ix;
        list_result_t            none;
        none = '{default: '0};
        op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_READ;
        case ($urandom_range(0, 9))
            0:       v = {1'b1, {(VAL_W-1){1'b0}}};
            1:       v = {1'b0, {(VAL_W-1){1'b1}}};
            2, 3:    v = int'($urandom_range(0, 16)) - 8;
            default: v = $urandom;
        endcase
        if (shadow_len != 0 && $urandom_range(0, 9) < 8)
            ix = IDX_W'($urandom_range(0, shadow_len - 1));
        else
            ix = IDX_W'($urandom);
        send_item(op, v, ix, 1'b0, none);
    endtask

    // receiver: random stall, one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= !steady && ($urandom_range(0, 99) < 19);
        end
    end

    always @(posedge clk)
    begin
        list_result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report("beat with nothing pending", VAL_W'(status), '0);
            else
            begin
                w = pending_results.pop_front();
                if (status !== w.status)
                    report("status", VAL_W'(status), VAL_W'(w.status));
                if (insert_position !== w.pos)
                    report("insert_position", VAL_W'(insert_position), VAL_W'(w.pos));
                if (read_value !== w.rdval)
                    report("read_value", read_value, w.rdval);
                if (element_total !== w.total)
                    report("element_total", VAL_W'(element_total), VAL_W'(w.total));
                if (is_full !== w.full)
                    report("is_full", VAL_W'(is_full), VAL_W'(w.full));
                if (is_empty !== w.empty)
                    report("is_empty", VAL_W'(is_empty), VAL_W'(w.empty));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_CAPACITY;
        cfg_data      = '0;
        in_valid      = 1'b0;
        mode          = OP_INSERT;
        value         = '0;
        index         = '0;
        n_errors      = 0;
        quiet_cycles  = 0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        shadow_len    = 0;
        shadow_cap    = CAP_RESET;
        shadow_sorted = 1'b0;
        foreach (shadow_mem[k])
            shadow_mem[k] = '0;

        // empty list, zero capacity, appends to a capacity of three
        plan.push_back(chk_row(OP_READ, 0, 0, STAT_RANGE, 0, 0, 0, 0, 1));
        plan.push_back(chk_row(OP_READ, 0, 255, STAT_RANGE, 0, 0, 0, 0, 1));
        plan.push_back(cfg_row(REG_CAPACITY, 0));
        plan.push_back(chk_row(OP_INSERT, 5, 0, STAT_FULL, 0, 0, 0, 1, 1));
        plan.push_back(chk_row(OP_READ, 0, 0, STAT_RANGE, 0, 0, 0, 1, 1));
        plan.push_back(cfg_row(REG_CAPACITY, 3));
        plan.push_back(chk_row(OP_INSERT, 32'h7FFF_FFFF, 0, STAT_OK, 0, 0, 1, 0, 0));
        plan.push_back(chk_row(OP_INSERT, 32'h8000_0000, 0, STAT_OK, 1, 0, 2, 0, 0));
        plan.push_back(chk_row(OP_INSERT, 0, 0, STAT_OK, 2, 0, 3, 1, 0));
        plan.push_back(chk_row(OP_INSERT, 32'hFFFF_FFFF, 0, STAT_FULL, 0, 0, 3, 1, 0));
        plan.push_back(chk_row(OP_READ, 0, 0, STAT_OK, 0, 32'h7FFF_FFFF, 3, 1, 0));
        plan.push_back(chk_row(OP_READ, 0, 1, STAT_OK, 0, 32'h8000_0000, 3, 1, 0));
        plan.push_back(chk_row(OP_READ, 0, 3, STAT_RANGE, 0, 0, 3, 1, 0));
        // sorted inserts into an unordered list, duplicates
        plan.push_back(cfg_row(REG_SORTED, 1));
        plan.push_back(cfg_row(REG_CAPACITY, 9));
        plan.push_back(op_row(OP_INSERT, 0, 0));
        plan.push_back(op_row(OP_INSERT, 32'h8000_0000, 0));
        plan.push_back(op_row(OP_INSERT, 32'h7FFF_FFFF, 0));
        plan.push_back(op_row(OP_INSERT, 32'hFFFF_FFFF, 0));
        plan.push_back(op_row(OP_INSERT, 0, 0));
        plan.push_back(op_row(OP_READ, 0, 0));
        // capacity below count, then above depth
        plan.push_back(cfg_row(REG_CAPACITY, 2));
        plan.push_back(chk_row(OP_INSERT, 1, 0, STAT_FULL, 0, 0, 8, 1, 0));
        plan.push_back(op_row(OP_READ, 0, 7));
        plan.push_back(cfg_row(REG_CAPACITY, 511));
        plan.push_back(op_row(OP_INSERT, 3, 0));
        plan.push_back(op_row(OP_READ, 0, 8));
        plan.push_back(cfg_row(REG_SORTED, 0));
        plan.push_back(op_row(OP_INSERT, 42, 0));
        plan.push_back(op_row(OP_READ, 0, 255));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[k])
        begin
            if (plan[k].is_cfg)
                write_reg(plan[k].sel, plan[k].word);
            else
                send_item(plan[k].op, plan[k].val, plan[k].idx, plan[k].typed, plan[k].want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_CAPACITY, PHASE_CAP[p]);
            write_reg(REG_SORTED, CFG_W'(PHASE_SORTED[p]));
            steady = (p == 1);
            if (p == 2)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS[p]; n++)
            begin
                if (p == 0 && n == PHASE_ITEMS[p] / 2)
                    drain();
                random_item(PHASE_INS_PCT[p]);
            end
        end

        drain();
        repeat (300) @(negedge clk);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/bsli_pkg.sv
rtl/bounded_sorted_list_insert_core.sv
test/tb.sv
